// ===== design/assert_macros.svh =====
// Assertion macros shared by the unescape unit RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, a, b)
`define ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

// ===== design/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape unit.
// No dependencies.
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [2:0] ST_BYTE       = 3'd0;
  localparam logic [2:0] ST_CLOSED     = 3'd1;
  localparam logic [2:0] ST_UNTERM     = 3'd2;
  localparam logic [2:0] ST_TRUNC_ESC  = 3'd3;
  localparam logic [2:0] ST_BAD_ESC    = 3'd4;
  localparam logic [2:0] ST_BAD_PAIR   = 3'd5;
  localparam logic [2:0] ST_TRUNC_PAIR = 3'd6;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  // one queued step: up to four bytes or a single status
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      nbytes_m1;
    logic [2:0]      status;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t data;
  } qwr_t;

endpackage

// ===== design/json_string_unescape_utf8_unit.sv =====
// JSON string body unescaper with UTF-8 output; top level, built on jsu_pkg.
// A result is registered in the step queue, then in jsu_back's cur_r.
// Throughput: one input byte per cycle while in_full is low; a step of n
// UTF-8 bytes leaves in n transfers, absorbed by the 4-entry step queue.
// Reset: synchronous active-low rst_n clears decode state, queue and output.
// Depends on jsu_front, jsu_queue, jsu_back.
module json_string_unescape_utf8_unit import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_data,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  qwr_t   qwr;
  entry_t q_data;
  logic   q_empty;
  logic   q_pop;
  logic   q_full;

  assign in_full = q_full;

  jsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_push && !q_full),
    .item   (in_data),
    .qwr    (qwr)
  );

  jsu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qwr   (qwr),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

// ===== design/jsu_front.sv =====
// Front end: escape/hex state machine, surrogate pairing and UTF-8 encode.
// Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output qwr_t     qwr
);

  localparam logic [2:0] MODE_PLAIN = 3'd0;
  localparam logic [2:0] MODE_ESC   = 3'd1;
  localparam logic [2:0] MODE_HEX0  = 3'd2;
  localparam logic [2:0] MODE_HEX1  = 3'd3;
  localparam logic [2:0] MODE_HEX2  = 3'd4;
  localparam logic [2:0] MODE_HEX3  = 3'd5;

  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] hex_accum_r, hex_accum_nxt;
  logic [9:0]  pending_high_r, pending_high_nxt;
  logic        pending_valid_r, pending_valid_nxt;

  function automatic logic [4:0] hex_value(input logic [7:0] x);
    logic [4:0] r;
    r = 5'd0;
    if (x >= 8'h30 && x <= 8'h39) r = {1'b1, x[3:0]};
    else if ((x >= 8'h41 && x <= 8'h46) || (x >= 8'h61 && x <= 8'h66))
      r = {1'b1, x[3:0] + 4'd9};
    return r;
  endfunction

  logic [7:0]  x;
  logic        eoi;
  logic [4:0]  hv;
  logic [15:0] acc_new;
  logic        unit_go;
  logic [15:0] u;
  logic        raw;
  logic        st_go;
  logic [2:0]  st;
  logic [20:0] cp;
  logic        enc_go;
  entry_t      ent;

  assign x       = item.in_byte;
  assign eoi     = item.end_of_input;
  assign hv      = hex_value(x);
  assign acc_new = {hex_accum_r[11:0], hv[3:0]};

  always_comb begin
    mode_nxt          = mode_r;
    hex_accum_nxt     = hex_accum_r;
    pending_high_nxt  = pending_high_r;
    pending_valid_nxt = pending_valid_r;
    unit_go = 1'b0;
    u       = 16'd0;
    raw     = 1'b0;
    st_go   = 1'b0;
    st      = ST_BYTE;
    enc_go  = 1'b0;
    cp      = 21'd0;

    case (mode_r)
      MODE_ESC: begin
        if (eoi) begin
          st_go = 1'b1;
          st    = ST_TRUNC_ESC;
        end else begin
          mode_nxt = MODE_PLAIN;
          unit_go  = 1'b1;
          case (x)
            8'h22:   u = 16'h0022;
            8'h5c:   u = 16'h005c;
            8'h2f:   u = 16'h002f;
            8'h62:   u = 16'h0008;
            8'h66:   u = 16'h000c;
            8'h6e:   u = 16'h000a;
            8'h72:   u = 16'h000d;
            8'h74:   u = 16'h0009;
            8'h75: begin
              unit_go       = 1'b0;
              mode_nxt      = MODE_HEX0;
              hex_accum_nxt = 16'd0;
            end
            default: begin
              unit_go = 1'b0;
              st_go   = 1'b1;
              st      = ST_BAD_ESC;
            end
          endcase
        end
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (eoi) begin
          st_go = 1'b1;
          st    = ST_TRUNC_ESC;
        end else if (!hv[4]) begin
          st_go = 1'b1;
          st    = ST_BAD_ESC;
        end else if (mode_r == MODE_HEX3) begin
          mode_nxt      = MODE_PLAIN;
          hex_accum_nxt = 16'd0;
          unit_go       = 1'b1;
          u             = acc_new;
        end else begin
          mode_nxt      = mode_r + 3'd1;
          hex_accum_nxt = acc_new;
        end
      end
      default: begin
        mode_nxt = MODE_PLAIN;
        if (eoi) begin
          st_go = 1'b1;
          st    = ST_UNTERM;
        end else if (x == 8'h22) begin
          st_go = 1'b1;
          st    = pending_valid_r ? ST_TRUNC_PAIR : ST_CLOSED;
        end else if (x == 8'h5c) begin
          mode_nxt = MODE_ESC;
        end else begin
          unit_go = 1'b1;
          u       = {8'd0, x};
          raw     = x[7];
        end
      end
    endcase

    if (unit_go) begin
      if (pending_valid_r) begin
        if (u[15:10] != 6'b110111) begin
          st_go = 1'b1;
          st    = ST_BAD_PAIR;
        end else begin
          cp                = 21'h10000 + {1'b0, pending_high_r, u[9:0]};
          enc_go            = 1'b1;
          pending_valid_nxt = 1'b0;
          pending_high_nxt  = 10'd0;
        end
      end else if (u[15:10] == 6'b110110) begin
        pending_high_nxt  = u[9:0];
        pending_valid_nxt = 1'b1;
      end else begin
        cp     = {5'd0, u};
        enc_go = 1'b1;
      end
    end

    if (st_go) begin
      mode_nxt          = MODE_PLAIN;
      hex_accum_nxt     = 16'd0;
      pending_high_nxt  = 10'd0;
      pending_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    ent        = '0;
    ent.status = st;
    if (!st_go) begin
      if (raw || cp < 21'h80) begin
        ent.bytes[0]  = cp[7:0];
        ent.nbytes_m1 = 2'd0;
      end else if (cp < 21'h800) begin
        ent.bytes[0]  = {3'b110, cp[10:6]};
        ent.bytes[1]  = {2'b10, cp[5:0]};
        ent.nbytes_m1 = 2'd1;
      end else if (cp < 21'h10000) begin
        ent.bytes[0]  = {4'b1110, cp[15:12]};
        ent.bytes[1]  = {2'b10, cp[11:6]};
        ent.bytes[2]  = {2'b10, cp[5:0]};
        ent.nbytes_m1 = 2'd2;
      end else begin
        ent.bytes[0]  = {5'b11110, cp[20:18]};
        ent.bytes[1]  = {2'b10, cp[17:12]};
        ent.bytes[2]  = {2'b10, cp[11:6]};
        ent.bytes[3]  = {2'b10, cp[5:0]};
        ent.nbytes_m1 = 2'd3;
      end
    end
  end

  assign qwr.push = accept && (st_go || enc_go);
  assign qwr.data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_PLAIN;
      hex_accum_r     <= 16'd0;
      pending_high_r  <= 10'd0;
      pending_valid_r <= 1'b0;
    end else if (accept) begin
      mode_r          <= mode_nxt;
      hex_accum_r     <= hex_accum_nxt;
      pending_high_r  <= pending_high_nxt;
      pending_valid_r <= pending_valid_nxt;
    end
  end

endmodule

// ===== design/jsu_queue.sv =====
// Short FIFO of decoded steps between front and back.
// Depends on jsu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jsu_queue import jsu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  qwr_t   qwr,
  output logic   full,
  input  logic   pop,
  output entry_t rdata,
  output logic   empty
);

  entry_t           mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == QCW'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = qwr.push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= qwr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      if (do_push && !do_pop)      count_r <= count_r + QCW'(1);
      else if (do_pop && !do_push) count_r <= count_r - QCW'(1);
    end
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_r <= QCW'(QDEPTH))
  `ASSERT_NEXT(a_count_inc, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + QCW'(1))
  `ASSERT_IMPLIES(a_ptr_gap, clk, rst_n, !full, QAW'(wr_ptr_r - rd_ptr_r) == count_r[QAW-1:0])

endmodule

// ===== design/jsu_back.sv =====
// Back end: walks each queued step out one result byte per transfer.
// Depends on jsu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jsu_back import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  entry_t    q_data,
  input  logic      q_empty,
  output logic      q_pop,
  output out_item_t out_item,
  output logic      out_empty,
  input  logic      out_pop
);

  entry_t     cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       is_last;
  logic       xfer;
  logic       cur_is_status;

  assign is_last       = (idx_r == cur_r.nbytes_m1);
  assign xfer          = out_pop && cur_valid_r;
  assign q_pop         = !q_empty && (!cur_valid_r || (xfer && is_last));
  assign out_empty     = !cur_valid_r;
  assign cur_is_status = cur_valid_r && (cur_r.status != ST_BYTE);

  assign out_item.out_byte = cur_r.bytes[idx_r];
  assign out_item.status   = cur_r.status;
  assign out_item.last     = is_last;

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (xfer) begin
      if (is_last) cur_valid_r <= 1'b0;
      else         idx_r <= idx_r + 2'd1;
    end
  end

  `ASSERT_IMPLIES(a_status_single, clk, rst_n, cur_is_status, cur_r.nbytes_m1 == 2'd0)
  `ASSERT_IMPLIES(a_idx_bound, clk, rst_n, cur_valid_r, idx_r <= cur_r.nbytes_m1)
  `ASSERT_NEXT(a_hold_out, clk, rst_n, cur_valid_r && !out_pop, out_item == $past(out_item))

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for json_string_unescape_utf8_unit.
// Drives string-body bytes through the push/full queue port and checks each
// UTF-8 byte or status result against a built-in decoder or a directed table; depends on jsu_pkg.
module tb import jsu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    M_PLAIN = 3'd0,
    M_ESC   = 3'd1,
    M_HEX0  = 3'd2,
    M_HEX1  = 3'd3,
    M_HEX2  = 3'd4,
    M_HEX3  = 3'd5
  } dec_mode_e;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] ESC_CH [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH,
                                        8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
  localparam out_item_t NO_RES = '0;
  localparam int RAND_ITEMS = 360;
  localparam int HOLD_CYCLES = 80;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  in_item_t  in_data;
  logic      in_full;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  json_string_unescape_utf8_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // decoder state
  dec_mode_e   dec_mode;
  logic [15:0] hex_acc;
  logic [9:0]  pend_high;
  logic        pend_valid;

  out_item_t step_out_q [$];
  out_item_t decoded_q [$];
  in_item_t  stim_q [$];
  int        faults;
  bit        calm;
  bit        hold_req;
  int        hold_left;

  dir_row_t dir_tab [27] = '{
    '{'{CH_QUOTE, 1'b0}, 1'b1, '{8'h00, ST_CLOSED, 1'b1}},
    '{'{8'h00, 1'b0}, 1'b1, '{8'h00, ST_BYTE, 1'b1}},
    '{'{8'hFF, 1'b0}, 1'b1, '{8'hFF, ST_BYTE, 1'b1}},
    '{'{CH_BSLASH, 1'b0}, 1'b0, NO_RES},
    '{'{8'h78, 1'b0}, 1'b1, '{8'h00, ST_BAD_ESC, 1'b1}},
    '{'{CH_BSLASH, 1'b0}, 1'b0, NO_RES},
    '{'{8'hA5, 1'b1}, 1'b1, '{8'h00, ST_TRUNC_ESC, 1'b1}},
    '{'{8'h00, 1'b1}, 1'b1, '{8'h00, ST_UNTERM, 1'b1}},
    '{'{CH_BSLASH, 1'b0}, 1'b0, NO_RES},
    '{'{CH_U, 1'b0}, 1'b0, NO_RES},
    '{'{8'h44, 1'b0}, 1'b0, NO_RES},
    '{'{8'h42, 1'b0}, 1'b0, NO_RES},
    '{'{8'h46, 1'b0}, 1'b0, NO_RES},
    '{'{8'h46, 1'b0}, 1'b0, NO_RES},
    '{'{CH_BSLASH, 1'b0}, 1'b0, NO_RES},
    '{'{CH_U, 1'b0}, 1'b0, NO_RES},
    '{'{8'h64, 1'b0}, 1'b0, NO_RES},
    '{'{8'h63, 1'b0}, 1'b0, NO_RES},
    '{'{8'h30, 1'b0}, 1'b0, NO_RES},
    '{'{8'h30, 1'b0}, 1'b0, NO_RES},
    '{'{CH_BSLASH, 1'b0}, 1'b0, NO_RES},
    '{'{CH_U, 1'b0}, 1'b0, NO_RES},
    '{'{8'h44, 1'b0}, 1'b0, NO_RES},
    '{'{8'h38, 1'b0}, 1'b0, NO_RES},
    '{'{8'h30, 1'b0}, 1'b0, NO_RES},
    '{'{8'h30, 1'b0}, 1'b0, NO_RES},
    '{'{CH_QUOTE, 1'b0}, 1'b1, '{8'h00, ST_TRUNC_PAIR, 1'b1}}
  };

  function automatic int hex_digit_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  function automatic void reset_decoder();
    dec_mode = M_PLAIN;
    hex_acc = '0;
    pend_high = '0;
    pend_valid = 1'b0;
  endfunction

  function automatic void emit_status(logic [2:0] st);
    step_out_q.push_back('{8'h00, st, 1'b1});
    reset_decoder();
  endfunction

  function automatic void emit_unit(logic [20:0] u, bit raw);
    logic [20:0] cp;
    logic [7:0]  b [4];
    int          n;
    cp = u;
    if (pend_valid) begin
      if (!(cp >= 21'hDC00 && cp < 21'hE000)) begin
        emit_status(ST_BAD_PAIR);
        return;
      end
      cp = 21'h10000 + {1'b0, pend_high, cp[9:0]};
      pend_valid = 1'b0;
      pend_high = '0;
    end else if (cp >= 21'hD800 && cp < 21'hDC00) begin
      pend_high = cp[9:0];
      pend_valid = 1'b1;
      return;
    end
    if (raw || cp < 21'h80) begin
      b[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
      n = 4;
    end
    for (int k = 0; k < n; k++) begin
      step_out_q.push_back('{b[k], ST_BYTE, (k == n - 1)});
    end
  endfunction

  // one input byte through the decoder; results land in step_out_q
  function automatic void unescape_step(in_item_t it);
    logic [7:0] x;
    int         d;
    x = it.in_byte;
    if (dec_mode == M_ESC) begin
      if (it.end_of_input) begin
        emit_status(ST_TRUNC_ESC);
        return;
      end
      dec_mode = M_PLAIN;
      case (x)
        CH_QUOTE:  emit_unit(21'h22, 1'b0);
        CH_BSLASH: emit_unit(21'h5C, 1'b0);
        CH_SLASH:  emit_unit(21'h2F, 1'b0);
        8'h62:     emit_unit(21'h08, 1'b0);
        8'h66:     emit_unit(21'h0C, 1'b0);
        8'h6E:     emit_unit(21'h0A, 1'b0);
        8'h72:     emit_unit(21'h0D, 1'b0);
        8'h74:     emit_unit(21'h09, 1'b0);
        CH_U: begin
          dec_mode = M_HEX0;
          hex_acc = '0;
        end
        default:   emit_status(ST_BAD_ESC);
      endcase
    end else if (dec_mode >= M_HEX0 && dec_mode <= M_HEX3) begin
      if (it.end_of_input) begin
        emit_status(ST_TRUNC_ESC);
        return;
      end
      d = hex_digit_val(x);
      if (d < 0) begin
        emit_status(ST_BAD_ESC);
        return;
      end
      hex_acc = {hex_acc[11:0], 4'(d)};
      if (dec_mode == M_HEX3) begin
        dec_mode = M_PLAIN;
        d = int'(hex_acc);
        hex_acc = '0;
        emit_unit(21'(d), 1'b0);
      end else begin
        dec_mode = dec_mode_e'(dec_mode + 3'd1);
      end
    end else begin
      dec_mode = M_PLAIN;
      if (it.end_of_input) emit_status(ST_UNTERM);
      else if (x == CH_QUOTE) emit_status(pend_valid ? ST_TRUNC_PAIR : ST_CLOSED);
      else if (x == CH_BSLASH) dec_mode = M_ESC;
      else emit_unit({13'd0, x}, x >= 8'h80);
    end
  endfunction

  function automatic void note_fault(string msg);
    faults++;
    if (faults <= 10) $display("ERROR: %s", msg);
  endfunction

  // stimulus building blocks
  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'd0, v};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
  endfunction

  function automatic bit is_esc_letter(logic [7:0] c);
    if (c == CH_U) return 1'b1;
    foreach (ESC_CH[i]) if (ESC_CH[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void push_ch(logic [7:0] c);
    stim_q.push_back('{c, 1'b0});
  endfunction

  function automatic void push_eoi();
    stim_q.push_back('{8'($urandom), 1'b1});
  endfunction

  function automatic void push_hex_esc(logic [15:0] v);
    push_ch(CH_BSLASH);
    push_ch(CH_U);
    for (int i = 3; i >= 0; i--) push_ch(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic void push_simple_esc();
    push_ch(CH_BSLASH);
    push_ch(ESC_CH[$urandom_range(0, 7)]);
  endfunction

  function automatic void add_token();
    int          pick;
    int          k;
    logic [7:0]  c;
    logic [15:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      c = 8'($urandom_range(0, 127));
      if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h7E;
      push_ch(c);
    end else if (pick < 35) begin
      push_ch(8'($urandom_range(128, 255)));
    end else if (pick < 45) begin
      push_simple_esc();
    end else if (pick < 60) begin
      case ($urandom_range(0, 3))
        0: v = 16'($urandom_range(0, 'h7F));
        1: v = 16'($urandom_range('h80, 'h7FF));
        2: v = 16'($urandom_range('h800, 'hD7FF));
        default: v = 16'($urandom_range('hE000, 'hFFFF));
      endcase
      push_hex_esc(v);
    end else if (pick < 70) begin
      push_hex_esc(16'($urandom_range('hD800, 'hDBFF)));
      push_hex_esc(16'($urandom_range('hDC00, 'hDFFF)));
    end else if (pick < 78) begin
      push_ch(CH_QUOTE);
    end else if (pick < 80) begin
      push_hex_esc(16'($urandom_range('hDC00, 'hDFFF)));
    end else if (pick < 84) begin
      // high surrogate followed by something other than a low one
      push_hex_esc(16'($urandom_range('hD800, 'hDBFF)));
      case ($urandom_range(0, 4))
        0: push_ch(8'($urandom));
        1: push_simple_esc();
        2: push_hex_esc(16'($urandom_range(0, 'hDBFF)));
        3: push_ch(CH_QUOTE);
        default: push_eoi();
      endcase
    end else if (pick < 88) begin
      k = $urandom_range(0, 5);
      if (k >= 1) push_ch(CH_BSLASH);
      if (k >= 2) push_ch(CH_U);
      for (int i = 2; i < k; i++) push_ch(hex_char(4'($urandom)));
      push_eoi();
    end else if (pick < 92) begin
      do c = 8'($urandom); while (is_esc_letter(c));
      push_ch(CH_BSLASH);
      push_ch(c);
    end else if (pick < 96) begin
      push_ch(CH_BSLASH);
      push_ch(CH_U);
      k = $urandom_range(0, 3);
      for (int i = 0; i < k; i++) push_ch(hex_char(4'($urandom)));
      do c = 8'($urandom); while (hex_digit_val(c) >= 0);
      push_ch(c);
    end else if (pick < 99) begin
      push_ch(8'($urandom));
    end else begin
      push_eoi();
    end
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    while (!calm && hold_left == 0 && !hold_req && $urandom_range(0, 99) < 36) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    step_out_q.delete();
    unescape_step(it);
    if (typed) decoded_q.push_back(want);
    else foreach (step_out_q[i]) decoded_q.push_back(step_out_q[i]);
    @(negedge clk);
  endtask

  // result side
  initial begin
    out_pop = 1'b0;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (decoded_q.size() == 0) begin
        note_fault($sformatf("unexpected result byte %02h status %0d last %0d",
                             out_item.out_byte, out_item.status, out_item.last));
      end else begin
        want = decoded_q.pop_front();
        if (out_item.out_byte !== want.out_byte || out_item.status !== want.status ||
            out_item.last !== want.last)
          note_fault($sformatf("got byte %02h status %0d last %0d, expected %02h %0d %0d",
                               out_item.out_byte, out_item.status, out_item.last,
                               want.out_byte, want.status, want.last));
      end
    end
  end

  initial begin
    int rand_sent;
    in_item_t it;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    faults = 0;
    reset_decoder();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      add_token();
      while (stim_q.size() != 0) begin
        it = stim_q.pop_front();
        if (rand_sent == 80) hold_req = 1'b1;
        if (rand_sent == 200) begin
          // let the unit drain completely before continuing
          in_push <= 1'b0;
          @(negedge clk);
          while (decoded_q.size() != 0) @(negedge clk);
        end
        calm = (rand_sent >= 240 && rand_sent < 320);
        send_item(it, 1'b0, NO_RES);
        rand_sent++;
      end
    end
    calm = 1'b0;
    in_push <= 1'b0;

    while (decoded_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (decoded_q.size() != 0) note_fault("results still outstanding at end of run");
    if (faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
